// ===== rtl/light_level_seven_segment_scan_top_assert.svh =====
// assertion macros for the light level seven segment scan block
// used by light_level_seven_segment_scan_top; expects aclk and aresetn in scope
`ifndef LIGHT_LEVEL_SEVEN_SEGMENT_SCAN_TOP_ASSERT_SVH
`define LIGHT_LEVEL_SEVEN_SEGMENT_SCAN_TOP_ASSERT_SVH

// same-cycle implication, checked outside reset
`define LLS_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked outside reset
`define LLS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/lls_pkg.sv =====
// shared types, constants and decode functions for the light level display scan
// no dependencies; used by lls_front, lls_queue, lls_back and the top level
package lls_pkg;

    localparam int SAMPLE_W    = 10;
    localparam int DIGIT_W     = 4;
    localparam int NUM_DIGITS  = 4;
    localparam int POS_W       = 2;
    localparam int SEG_W       = 7;
    localparam int S_TDATA_W   = 16;
    localparam int M_TDATA_W   = 16;
    localparam int Q_DEPTH     = 2;
    localparam int Q_PTR_W     = 1;
    localparam int Q_CNT_W     = $clog2(Q_DEPTH + 1);

    localparam logic [SAMPLE_W-1:0]   DARK_THRESHOLD_RESET = 10'd512;
    localparam logic [SEG_W-1:0]      SEG_BLANK_N          = 7'h7F;
    localparam logic [NUM_DIGITS-1:0] ENABLES_OFF_N        = 4'hF;

    typedef enum logic {
        OP_SAMPLE = 1'b0,
        OP_TICK   = 1'b1
    } op_t;

    typedef logic [NUM_DIGITS-1:0][DIGIT_W-1:0] digits_t;

    // classified item passed from front to back
    typedef struct packed {
        op_t     op;
        digits_t digits;
        logic    lamp;
    } item_t;

    // queue status seen by the front and back
    typedef struct packed {
        logic full;
        logic valid;
    } q_status_t;

    // active-high segment codes for digits 0..9, bit 0 is segment a
    localparam logic [9:0][SEG_W-1:0] SEG_CODE = {
        7'h6F, 7'h7F, 7'h07, 7'h7D, 7'h6D, 7'h66, 7'h4F, 7'h5B, 7'h06, 7'h3F
    };

    // active-low pattern for one digit, blank above nine
    function automatic logic [SEG_W-1:0] seg_decode(logic [DIGIT_W-1:0] digit);
        logic [SEG_W-1:0] seg;
        if (digit > 4'd9) begin
            seg = SEG_BLANK_N;
        end else begin
            seg = ~SEG_CODE[digit];
        end
        return seg;
    endfunction

    // split a sample into four decimal digits, thousands in entry 0
    function automatic digits_t bcd_split(logic [SAMPLE_W-1:0] v);
        digits_t       d;
        logic [9:0]    r1;
        logic [6:0]    r2;
        logic [3:0]    hun;
        logic [3:0]    ten;
        d[0] = (v >= 10'd1000) ? 4'd1 : 4'd0;
        r1   = (v >= 10'd1000) ? (v - 10'd1000) : v;
        hun  = 4'd0;
        for (int k = 1; k <= 9; k++) begin
            if (r1 >= 10'(100 * k)) begin
                hun = 4'(k);
            end
        end
        r2  = 7'(r1 - ({6'd0, hun} * 10'd100));
        ten = 4'd0;
        for (int k = 1; k <= 9; k++) begin
            if (r2 >= 7'(10 * k)) begin
                ten = 4'(k);
            end
        end
        d[1] = hun;
        d[2] = ten;
        d[3] = 4'(r2 - ({3'd0, ten} * 7'd10));
        return d;
    endfunction

endpackage

// ===== rtl/light_level_seven_segment_scan_top.sv =====
// an accepted request is written into the queue, then popped into the held result register
// throughput: one request per cycle while the queue is not full; the two-entry queue absorbs result stalls
// each request yields exactly one result, the held segment, enable and lamp levels
// reset (aresetn low, synchronous): threshold 512, digits zero, scan position zero,
// segments and enables all ones (blank, off), lamp off, queue and result empty
module light_level_seven_segment_scan_top (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_wr_en,
    input  logic [lls_pkg::SAMPLE_W-1:0]      cfg_wr_data,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [lls_pkg::S_TDATA_W-1:0]     s_tdata,   // [9:0] sample, rest zero
    input  logic                              s_tuser,   // [0] opcode
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [lls_pkg::M_TDATA_W-1:0]     m_tdata    // [6:0] segments_n,
                                                         // [10:7] digit_enable_n,
                                                         // [11] lamp_on, rest zero
);

    `include "light_level_seven_segment_scan_top_assert.svh"

    lls_pkg::q_status_t q_status;
    lls_pkg::item_t     push_item;
    lls_pkg::item_t     pop_item;
    logic               q_push;
    logic               q_pop;

    // request classification
    lls_front u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .q_status    (q_status),
        .q_push      (q_push),
        .q_push_item (push_item)
    );

    // decoupling queue
    lls_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_item (push_item),
        .pop       (q_pop),
        .pop_item  (pop_item),
        .status    (q_status)
    );

    // state update and result
    lls_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_status (q_status),
        .q_item   (pop_item),
        .q_pop    (q_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    // checks
    `LLS_ASSERT_NOW(a_pop_needs_slot, q_pop, (!m_tvalid || m_tready), "pop into a stalled result")
    `LLS_ASSERT_NEXT(a_taken_empties, (m_tvalid && m_tready && !q_pop), !m_tvalid, "result repeated")
    `LLS_ASSERT_NEXT(a_tick_one_digit, (q_pop && pop_item.op == lls_pkg::OP_TICK), $onehot(~m_tdata[10:7]), "tick enabled not exactly one digit")

endmodule

// ===== rtl/lls_front.sv =====
// front end: takes input requests, holds the dark threshold, classifies samples
// depends on lls_pkg
module lls_front (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_wr_en,
    input  logic [lls_pkg::SAMPLE_W-1:0]      cfg_wr_data,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [lls_pkg::S_TDATA_W-1:0]     s_tdata,   // [9:0] sample, rest zero
    input  logic                              s_tuser,   // [0] opcode
    input  lls_pkg::q_status_t                q_status,
    output logic                              q_push,
    output lls_pkg::item_t                    q_push_item
);

    logic [lls_pkg::SAMPLE_W-1:0] threshold_reg;
    logic [lls_pkg::SAMPLE_W-1:0] sample;

    // dark threshold register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            threshold_reg <= lls_pkg::DARK_THRESHOLD_RESET;
        end else if (cfg_wr_en) begin
            threshold_reg <= cfg_wr_data;
        end
    end

    // accept whenever the queue has room
    assign s_tready = !q_status.full;
    assign q_push   = s_tvalid && s_tready;
    assign sample   = s_tdata[lls_pkg::SAMPLE_W-1:0];

    // classify the request: digit split and lamp compare for samples
    always_comb begin
        q_push_item.op     = lls_pkg::op_t'(s_tuser);
        q_push_item.digits = lls_pkg::bcd_split(sample);
        q_push_item.lamp   = (sample < threshold_reg);
    end

endmodule

// ===== rtl/lls_queue.sv =====
// two-entry request queue between front and back
// depends on lls_pkg
module lls_queue (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               push,
    input  lls_pkg::item_t     push_item,
    input  logic               pop,
    output lls_pkg::item_t     pop_item,
    output lls_pkg::q_status_t status
);

    lls_pkg::item_t                 mem_reg [lls_pkg::Q_DEPTH];
    logic [lls_pkg::Q_PTR_W-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [lls_pkg::Q_PTR_W-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [lls_pkg::Q_CNT_W-1:0]    count_reg, count_next;

    // pointer and fill count update
    always_comb begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop  ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // entry storage
    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_item;
        end
    end

    assign pop_item     = mem_reg[rd_ptr_reg];
    assign status.full  = (count_reg == lls_pkg::Q_CNT_W'(lls_pkg::Q_DEPTH));
    assign status.valid = (count_reg != '0);

endmodule

// ===== rtl/lls_back.sv =====
// back end: applies queued requests to the digit store and scan state, drives results
// depends on lls_pkg
module lls_back (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  lls_pkg::q_status_t               q_status,
    input  lls_pkg::item_t                   q_item,
    output logic                             q_pop,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [lls_pkg::M_TDATA_W-1:0]    m_tdata   // [6:0] segments_n,
                                                       // [10:7] digit_enable_n,
                                                       // [11] lamp_on, rest zero
);

    lls_pkg::digits_t                 digits_reg, digits_next;
    logic [lls_pkg::POS_W-1:0]        pos_reg, pos_next;
    logic [lls_pkg::SEG_W-1:0]        seg_reg, seg_next;
    logic [lls_pkg::NUM_DIGITS-1:0]   en_reg, en_next;
    logic                             lamp_reg, lamp_next;
    logic                             valid_reg, valid_next;

    // take the next request when the result slot is free or being taken
    assign q_pop = q_status.valid && (!valid_reg || m_tready);

    // state update for the popped request
    always_comb begin
        digits_next = digits_reg;
        pos_next    = pos_reg;
        seg_next    = seg_reg;
        en_next     = en_reg;
        lamp_next   = lamp_reg;
        valid_next  = valid_reg && !m_tready;
        if (q_pop) begin
            valid_next = 1'b1;
            unique case (q_item.op)
                lls_pkg::OP_SAMPLE: begin
                    digits_next = q_item.digits;
                    lamp_next   = q_item.lamp;
                end
                lls_pkg::OP_TICK: begin
                    seg_next = lls_pkg::seg_decode(digits_reg[pos_reg]);
                    en_next  = ~(lls_pkg::NUM_DIGITS'(1) << pos_reg);
                    pos_next = pos_reg + 1'b1;
                end
                default: begin
                    valid_next = 1'b1;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            digits_reg <= '0;
            pos_reg    <= '0;
            seg_reg    <= lls_pkg::SEG_BLANK_N;
            en_reg     <= lls_pkg::ENABLES_OFF_N;
            lamp_reg   <= 1'b0;
            valid_reg  <= 1'b0;
        end else begin
            digits_reg <= digits_next;
            pos_reg    <= pos_next;
            seg_reg    <= seg_next;
            en_reg     <= en_next;
            lamp_reg   <= lamp_next;
            valid_reg  <= valid_next;
        end
    end

    // held levels are the result register
    assign m_tvalid = valid_reg;
    assign m_tdata  = {4'd0, lamp_reg, en_reg, seg_reg};

endmodule

// ===== sim/tb_light_level_seven_segment_scan_top.sv =====
// self-checking testbench for light_level_seven_segment_scan_top: directed table, then random requests
// depends on lls_pkg and the rtl top; results are checked against an in-bench display predictor
`timescale 1ns / 100ps

module tb_light_level_seven_segment_scan_top;
    import lls_pkg::*;

    localparam int CYCLE_LIMIT = 200000;

    // one result as seen on m_tdata
    typedef struct packed {
        logic [SEG_W-1:0]      seg_n;
        logic [NUM_DIGITS-1:0] en_n;
        logic                  lamp;
    } display_t;

    // directed table row, want is used only when typed is set
    typedef struct packed {
        op_t               op;
        logic [SAMPLE_W-1:0] level;
        logic              typed;
        display_t          want;
    } stim_row_t;

    localparam display_t NO_WANT = '0;

    logic                  aclk        = 1'b0;
    logic                  aresetn     = 1'b0;
    logic                  cfg_wr_en   = 1'b0;
    logic [SAMPLE_W-1:0]   cfg_wr_data = '0;
    logic                  s_tvalid    = 1'b0;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata     = '0;
    logic                  s_tuser     = 1'b0;
    logic                  m_tvalid;
    logic                  m_tready    = 1'b0;
    logic [M_TDATA_W-1:0]  m_tdata;

    int send_idle_pct = 36;
    int recv_idle_pct = 48;
    int error_count   = 0;
    int cycle_count   = 0;

    // predictor state
    logic [DIGIT_W-1:0]    shown_digits [NUM_DIGITS];
    logic [POS_W-1:0]      scan_pos   = '0;
    logic [SEG_W-1:0]      seg_held   = 7'h7F;
    logic [NUM_DIGITS-1:0] en_held    = 4'hF;
    logic                  lamp_held  = 1'b0;
    logic [SAMPLE_W-1:0]   dark_level = 10'd512;

    display_t pending_display [$];
    display_t got_display;
    display_t want_display;

    stim_row_t directed_rows [24] = '{
        '{OP_SAMPLE, 10'd511,  1'b1, '{7'h7F, 4'hF, 1'b1}},
        '{OP_SAMPLE, 10'd512,  1'b1, '{7'h7F, 4'hF, 1'b0}},
        '{OP_TICK,   10'd0,    1'b0, NO_WANT},
        '{OP_TICK,   10'd0,    1'b0, NO_WANT},
        '{OP_TICK,   10'd0,    1'b0, NO_WANT},
        '{OP_TICK,   10'd0,    1'b0, NO_WANT},
        '{OP_SAMPLE, 10'd1023, 1'b0, NO_WANT},
        '{OP_TICK,   10'd0,    1'b0, NO_WANT},
        '{OP_TICK,   10'd0,    1'b0, NO_WANT},
        '{OP_TICK,   10'd0,    1'b0, NO_WANT},
        '{OP_TICK,   10'd0,    1'b0, NO_WANT},
        '{OP_SAMPLE, 10'd0,    1'b0, NO_WANT},
        '{OP_TICK,   10'd1023, 1'b0, NO_WANT},
        '{OP_SAMPLE, 10'd987,  1'b0, NO_WANT},
        '{OP_TICK,   10'd0,    1'b0, NO_WANT},
        '{OP_TICK,   10'd0,    1'b0, NO_WANT},
        '{OP_TICK,   10'd0,    1'b0, NO_WANT},
        '{OP_TICK,   10'd0,    1'b0, NO_WANT},
        '{OP_SAMPLE, 10'd654,  1'b0, NO_WANT},
        '{OP_TICK,   10'd0,    1'b0, NO_WANT},
        '{OP_TICK,   10'd0,    1'b0, NO_WANT},
        '{OP_TICK,   10'd0,    1'b0, NO_WANT},
        '{OP_TICK,   10'd0,    1'b0, NO_WANT},
        '{OP_SAMPLE, 10'd1000, 1'b0, NO_WANT}
    };

    light_level_seven_segment_scan_top u_top (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    // active-low pattern of one digit, blank above nine
    function automatic logic [SEG_W-1:0] digit_pattern_n(logic [DIGIT_W-1:0] d);
        logic [SEG_W-1:0] lit;
        case (d)
            4'd0:    lit = 7'h3F;
            4'd1:    lit = 7'h06;
            4'd2:    lit = 7'h5B;
            4'd3:    lit = 7'h4F;
            4'd4:    lit = 7'h66;
            4'd5:    lit = 7'h6D;
            4'd6:    lit = 7'h7D;
            4'd7:    lit = 7'h07;
            4'd8:    lit = 7'h7F;
            4'd9:    lit = 7'h6F;
            default: lit = 7'h00;
        endcase
        return ~lit;
    endfunction

    // advance the display model by one request and return the held levels
    task automatic predict_display(input op_t op, input logic [SAMPLE_W-1:0] v,
                                   output display_t r);
        int n;
        int p;
        n = v;
        p = scan_pos;
        if (op == OP_SAMPLE) begin
            shown_digits[0] = 4'((n / 1000) % 10);
            shown_digits[1] = 4'((n / 100) % 10);
            shown_digits[2] = 4'((n / 10) % 10);
            shown_digits[3] = 4'(n % 10);
            lamp_held       = (v < dark_level);
        end else begin
            seg_held = digit_pattern_n(shown_digits[p]);
            en_held  = ~(4'b0001 << p);
            scan_pos = scan_pos + 1'b1;
        end
        r = '{seg_held, en_held, lamp_held};
    endtask

    task automatic report_mismatch(input string field, input int got, input int want);
        $display("mismatch on %s: got 0x%0h, expected 0x%0h, cycle %0d",
                 field, got, want, cycle_count);
        error_count++;
    endtask

    // one request with random idle before it, expectation queued on acceptance
    task automatic send_request(input op_t op, input logic [SAMPLE_W-1:0] v,
                                input logic typed, input display_t typed_want);
        display_t want;
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= S_TDATA_W'(v);
        do @(posedge aclk); while (!s_tready);
        predict_display(op, v, want);
        pending_display.push_back(typed ? typed_want : want);
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (pending_display.size() != 0) @(posedge aclk);
    endtask

    task automatic write_threshold(input logic [SAMPLE_W-1:0] v);
        wait_drained();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v;
        @(posedge aclk);
        cfg_wr_en   <= 1'b0;
        dark_level = v;
    endtask

    // samples lean toward the threshold and the decimal edges
    function automatic logic [SAMPLE_W-1:0] pick_sample();
        int n;
        case ($urandom_range(3))
            0: n = int'(dark_level) + int'($urandom_range(2)) - 1;
            1: begin
                case ($urandom_range(3))
                    0:       n = 0;
                    1:       n = 1023;
                    2:       n = 999;
                    default: n = 1000;
                endcase
            end
            default: n = $urandom_range(1023);
        endcase
        if (n < 0) n = 0;
        if (n > 1023) n = 1023;
        return SAMPLE_W'(n);
    endfunction

    // four times in ten a sample followed by a full scan, else a single random request
    task automatic run_random(input int count);
        int sent;
        sent = 0;
        while (sent < count) begin
            if ($urandom_range(9) < 4) begin
                send_request(OP_SAMPLE, pick_sample(), 1'b0, NO_WANT);
                repeat (4) send_request(OP_TICK, SAMPLE_W'($urandom_range(1023)), 1'b0, NO_WANT);
                sent += 5;
            end else if ($urandom_range(1) == 0) begin
                send_request(OP_SAMPLE, pick_sample(), 1'b0, NO_WANT);
                sent++;
            end else begin
                send_request(OP_TICK, SAMPLE_W'($urandom_range(1023)), 1'b0, NO_WANT);
                sent++;
            end
        end
    endtask

    // result side stalls
    always @(posedge aclk) begin
        m_tready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // compare each accepted result with the oldest expectation
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            got_display = '{m_tdata[6:0], m_tdata[10:7], m_tdata[11]};
            if (pending_display.size() == 0) begin
                report_mismatch("unexpected result", m_tdata, 0);
            end else begin
                want_display = pending_display.pop_front();
                if (got_display.seg_n !== want_display.seg_n)
                    report_mismatch("segments_n", got_display.seg_n, want_display.seg_n);
                if (got_display.en_n !== want_display.en_n)
                    report_mismatch("digit_enable_n", got_display.en_n, want_display.en_n);
                if (got_display.lamp !== want_display.lamp)
                    report_mismatch("lamp_on", got_display.lamp, want_display.lamp);
            end
        end
    end

    // run limit
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    initial begin
        int level;
        foreach (shown_digits[i]) shown_digits[i] = '0;

        // reset
        aresetn <= 1'b0;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;

        // directed table at the reset threshold
        foreach (directed_rows[i]) begin
            send_request(directed_rows[i].op, directed_rows[i].level,
                         directed_rows[i].typed, directed_rows[i].want);
        end

        // random phases, each with its own threshold; the idle mix changes at phases 3 and 5
        for (int ph = 1; ph <= 6; ph++) begin
            case (ph)
                1:       level = 0;
                2:       level = 1023;
                3:       level = 1;
                4:       level = $urandom_range(1023);
                5:       level = 1000;
                default: level = 512;
            endcase
            write_threshold(SAMPLE_W'(level));
            if (ph == 3) begin
                send_idle_pct = 48;
                recv_idle_pct = 36;
            end else if (ph == 5) begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            if (ph == 3) begin
                // halfway through, the sender holds off until every result is back
                run_random(125);
                wait_drained();
                run_random(125);
            end else begin
                run_random(250);
            end
        end

        wait_drained();
        repeat (4) @(posedge aclk);
        if (error_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
+incdir+rtl
rtl/lls_pkg.sv
rtl/lls_front.sv
rtl/lls_queue.sv
rtl/lls_back.sv
rtl/light_level_seven_segment_scan_top.sv
sim/tb_light_level_seven_segment_scan_top.sv
